/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deque RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define DEQ_ASSERT_ALWAYS(name, ck, rs, expr, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (expr)) \
    else $error(msg);

// ante implies cons in the same cycle
`define DEQ_ASSERT_IMPLY(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Deque package
// Types and constants shared by the double-ended queue blocks.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEQ_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_DUMP
  } back_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } result_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

/* rtl/double_ended_queue_unit.sv */
// Order: a push or pop status passes through the front command queue and the
//   result queue to the result ports; a dump's entries follow its RAM reads.
// Throughput: one push or pop per cycle while neither queue is full and no dump
//   runs; a dump holds the back end (one RAM read per entry), an empty one does not.
// Reset (rst, synchronous): queue empty, front index zero, no RAM clear.
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Front end decodes and queues commands, back end runs them on the ring store.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  deq_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output deq_pkg::result_t result
);

  import deq_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* rtl/deq_ram.sv */
// ----------------------------------------------------------------------------
// Deque RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/deq_front.sv */
// ----------------------------------------------------------------------------
// Deque front end
// Accepts input beats, decodes the kind, drops unused codes and holds
// decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module deq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  deq_pkg::item_t item,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output deq_pkg::cmd_t  cmd
);

  import deq_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       dec_ok;
  cmd_t       dec;
  logic       enq;
  logic       deq;

  always_comb begin
    dec_ok    = 1'b1;
    dec.value = item.value;
    dec.op    = OP_PUSH_FRONT;
    case (item.kind)
      KIND_PUSH_FRONT: dec.op = OP_PUSH_FRONT;
      KIND_PUSH_BACK:  dec.op = OP_PUSH_BACK;
      KIND_POP_FRONT:  dec.op = OP_POP_FRONT;
      KIND_POP_BACK:   dec.op = OP_POP_BACK;
      KIND_DUMP:       dec.op = OP_DUMP;
      default:         dec_ok = 1'b0;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign enq       = push && !full && dec_ok;
  assign deq       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) begin
        wp <= ~wp;
      end
      if (deq) begin
        rp <= ~rp;
      end
      case ({enq, deq})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* rtl/deq_back.sv */
// ----------------------------------------------------------------------------
// Deque back end
// Executes commands against the ring store, sequences dumps one entry per
// cycle while the output queue has room, buffers results in a small output queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_back #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  deq_pkg::cmd_t    cmd,
  output logic             empty,
  input  logic             pop,
  output deq_pkg::result_t result
);

  import deq_pkg::*;

  localparam int IW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = IW + 1;
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int OPW = $clog2(OUT_DEPTH);

  localparam logic [CW-1:0]  DEPTH_C     = CW'(DEPTH);
  localparam logic [SW-1:0]  DEPTH_S     = SW'(DEPTH);
  localparam logic [IW-1:0]  LAST_SLOT   = IW'(DEPTH - 1);
  localparam logic [OCW-1:0] OUT_CNT_MAX = OCW'(OUT_DEPTH);
  localparam logic [OPW-1:0] OUT_LAST    = OPW'(OUT_DEPTH - 1);

  back_state_t state, state_next;
  logic [IW-1:0] front_index, front_index_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] dump_ptr, dump_ptr_next;
  logic [CW-1:0] dump_idx, dump_idx_next;
  logic          rd_pend;
  logic          rd_last;
  logic          rd_en;
  logic          rd_last_next;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_rdata;

  logic                imm_valid;
  logic [STATUS_W-1:0] imm_status;
  logic [SW-1:0]       back_sum;
  logic [IW-1:0]       back_slot;
  logic [IW-1:0]       front_dec;
  logic [IW-1:0]       front_inc;
  logic [IW-1:0]       dump_inc;

  result_t        ofifo [OUT_DEPTH];
  logic [OPW-1:0] out_wp;
  logic [OPW-1:0] out_rp;
  logic [OCW-1:0] out_cnt;
  logic           out_we;
  logic           out_re;
  result_t        out_wdata;

  assign back_sum  = SW'(front_index) + SW'(count);
  assign back_slot = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : back_sum[IW-1:0];
  assign front_dec = (front_index == '0) ? LAST_SLOT : front_index - 1'b1;
  assign front_inc = (front_index == LAST_SLOT) ? '0 : front_index + 1'b1;
  assign dump_inc  = (dump_ptr == LAST_SLOT) ? '0 : dump_ptr + 1'b1;

  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    count_next       = count;
    dump_ptr_next    = dump_ptr;
    dump_idx_next    = dump_idx;
    cmd_ready        = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = back_slot;
    rd_en            = 1'b0;
    rd_last_next     = 1'b0;
    imm_valid        = 1'b0;
    imm_status       = ST_OK;
    case (state)
      BK_IDLE: begin
        if (cmd_valid && !rd_pend && (out_cnt < OUT_CNT_MAX)) begin
          cmd_ready = 1'b1;
          case (cmd.op)
            OP_PUSH_FRONT: begin
              imm_valid = 1'b1;
              if (count == DEPTH_C) begin
                imm_status = ST_FULL;
              end else begin
                front_index_next = front_dec;
                ram_we           = 1'b1;
                ram_waddr        = front_dec;
                count_next       = count + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              imm_valid = 1'b1;
              if (count == DEPTH_C) begin
                imm_status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              imm_valid = 1'b1;
              if (count == '0) begin
                imm_status = ST_EMPTY;
              end else begin
                front_index_next = front_inc;
                count_next       = count - 1'b1;
              end
            end
            OP_POP_BACK: begin
              imm_valid = 1'b1;
              if (count == '0) begin
                imm_status = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            OP_DUMP: begin
              if (count == '0) begin
                imm_valid  = 1'b1;
                imm_status = ST_EMPTY;
              end else begin
                state_next    = BK_DUMP;
                dump_ptr_next = front_index;
                dump_idx_next = '0;
              end
            end
            default: begin
              imm_valid = 1'b0;
            end
          endcase
        end
      end
      BK_DUMP: begin
        if ((out_cnt + OCW'(rd_pend)) < OUT_CNT_MAX) begin
          rd_en         = 1'b1;
          rd_last_next  = (dump_idx == count - 1'b1);
          dump_ptr_next = dump_inc;
          dump_idx_next = dump_idx + 1'b1;
          if (rd_last_next) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      front_index <= '0;
      count       <= '0;
      rd_pend     <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      count       <= count_next;
      rd_pend     <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    dump_ptr <= dump_ptr_next;
    dump_idx <= dump_idx_next;
    if (rd_en) begin
      rd_last <= rd_last_next;
    end
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.value),
    .re    (rd_en),
    .raddr (dump_ptr),
    .rdata (ram_rdata)
  );

  // result queue; a dump read's data arrives in the cycle after its issue
  always_comb begin
    out_wdata.status = imm_status;
    out_wdata.data   = '0;
    out_wdata.last   = 1'b1;
    if (rd_pend) begin
      out_wdata.status = ST_OK;
      out_wdata.data   = ram_rdata;
      out_wdata.last   = rd_last;
    end
  end

  assign out_we = imm_valid || rd_pend;
  assign empty  = (out_cnt == '0);
  assign out_re = pop && !empty;
  assign result = ofifo[out_rp];

  always_ff @(posedge clk) begin
    if (out_we) begin
      ofifo[out_wp] <= out_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wp  <= '0;
      out_rp  <= '0;
      out_cnt <= '0;
    end else begin
      if (out_we) begin
        out_wp <= (out_wp == OUT_LAST) ? '0 : out_wp + 1'b1;
      end
      if (out_re) begin
        out_rp <= (out_rp == OUT_LAST) ? '0 : out_rp + 1'b1;
      end
      case ({out_we, out_re})
        2'b10:   out_cnt <= out_cnt + 1'b1;
        2'b01:   out_cnt <= out_cnt - 1'b1;
        default: out_cnt <= out_cnt;
      endcase
    end
  end

  `DEQ_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= DEPTH_C, "entry count above depth")
  `DEQ_ASSERT_ALWAYS(a_ofifo_bound, clk, rst, out_cnt <= OUT_CNT_MAX, "result queue overflow")
  `DEQ_ASSERT_IMPLY(a_rd_from_dump, clk, rst, rd_pend, $past(state) == BK_DUMP, "stray read")
  `DEQ_ASSERT_IMPLY(a_dump_holds, clk, rst, state == BK_DUMP, count == $past(count), "count moved in dump")
  `DEQ_ASSERT_IMPLY(a_no_double_wr, clk, rst, rd_pend, !imm_valid, "two result writes at once")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives push/pop/dump beats into the deque, keeps a ring-store prediction of
// every status and dump entry, and checks each popped result in order.
// Covers the empty and full corner cases, spare kind codes, back-pressure
// from a long receiver hold-off, and a long random run with bursty traffic.
// ----------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_DUMP + 1'b1;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;

  logic clk;
  logic rst;
  logic push;
  logic full;
  item_t item;
  logic empty;
  logic pop = 1'b0;
  result_t result;

  double_ended_queue_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // deque prediction
  logic signed [DATA_W-1:0] ring [DEQ_DEPTH];
  int unsigned front_slot;
  int unsigned fill;
  result_t pending_results[$];

  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned dumps_sent;
  int unsigned full_refusals;
  int unsigned empty_reports;
  int unsigned mismatches;
  int unsigned cycle_count;

  // receiver control
  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left;
  int unsigned rx_mode;
  int unsigned rx_left;
  int unsigned rx_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void expect_result(logic [STATUS_W-1:0] status,
                                        logic signed [DATA_W-1:0] data,
                                        logic is_last);
    result_t r;
    r.status = status;
    r.data = data;
    r.last = is_last;
    pending_results.push_back(r);
    if (status == ST_FULL) full_refusals++;
    if (status == ST_EMPTY) empty_reports++;
  endfunction

  function automatic void apply_to_deque(item_t it);
    case (it.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (fill >= DEQ_DEPTH) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          if (it.kind == KIND_PUSH_FRONT) begin
            front_slot = (front_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
            ring[front_slot] = it.value;
          end else begin
            ring[(front_slot + fill) % DEQ_DEPTH] = it.value;
          end
          fill++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (it.kind == KIND_POP_FRONT) front_slot = (front_slot + 1) % DEQ_DEPTH;
          fill--;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      KIND_DUMP: begin
        dumps_sent++;
        if (fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++)
            expect_result(ST_OK, ring[(front_slot + i) % DEQ_DEPTH], i + 1 == fill);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // leaves push high; callers lower it through pause_sender or wait_drained
  task automatic send_beat(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value);
    item_t it;
    it.kind = kind;
    it.value = value;
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    apply_to_deque(it);
    if (kind <= KIND_DUMP) items_sent++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // receiver: long hold on request, otherwise a stall pattern that changes mode
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_left = 0;
    end else if (hold_flip != hold_seen) begin
      hold_seen = hold_flip;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(40, 120);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (rx_phase % 8) < 3;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : check_beat
    result_t want;
    if (!rst && pop && !empty) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat at %0t: status %0d data %0d last %0d", $time,
                   result.status, result.data, result.last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.data !== want.data ||
            result.last !== want.last) begin
          if (mismatches < 10)
            $display("mismatch at %0t: expected status %0d data %0d last %0d, got %0d %0d %0d",
                     $time, want.status, want.data, want.last,
                     result.status, result.data, result.last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_ops();
    send_beat(KIND_POP_FRONT, rand_word());
    send_beat(KIND_POP_BACK, rand_word());
    send_beat(KIND_DUMP, rand_word());
    for (int k = int'(KIND_SPARE_LO); k <= int'(KIND_SPARE_HI); k++)
      send_beat(KIND_W'(k), rand_word());
    send_beat(KIND_DUMP, '0);
  endtask

  task automatic test_directed();
    send_beat(KIND_PUSH_FRONT, 32'sh7fff_ffff);
    send_beat(KIND_PUSH_BACK, 32'sh8000_0000);
    send_beat(KIND_PUSH_FRONT, -32'sd1);
    send_beat(KIND_PUSH_BACK, '0);
    send_beat(KIND_DUMP, '0);
    send_beat(KIND_POP_FRONT, '0);
    send_beat(KIND_POP_BACK, '0);
    send_beat(KIND_DUMP, '0);
    send_beat(KIND_POP_BACK, '0);
    send_beat(KIND_POP_FRONT, '0);
    send_beat(KIND_POP_FRONT, '0);
    send_beat(KIND_PUSH_BACK, 32'sh5555_5555);
    send_beat(KIND_PUSH_FRONT, 32'shaaaa_aaaa);
    send_beat(KIND_DUMP, '0);
    send_beat(KIND_POP_FRONT, '0);
    send_beat(KIND_POP_BACK, '0);
    wait_drained();
  endtask

  // receiver holds off while the sender overfills the deque
  task automatic test_fill_stall();
    hold_flip <= ~hold_flip;
    for (int i = 0; i < DEQ_DEPTH + 4; i++)
      send_beat((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, rand_word());
    send_beat(KIND_DUMP, '0);
    wait_drained();
    for (int i = 0; i < DEQ_DEPTH + 1; i++)
      send_beat((i % 3) ? KIND_POP_BACK : KIND_POP_FRONT, '0);
    send_beat(KIND_DUMP, '0);
    wait_drained();
  endtask

  task automatic test_random(int unsigned target);
    int unsigned goal;
    int unsigned push_pct;
    int unsigned r;
    goal = items_sent + target;
    while (items_sent < goal) begin
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 25;
        default: push_pct = 50;
      endcase
      repeat ($urandom_range(1, 16)) begin
        r = $urandom_range(0, 99);
        if (r < 4)
          send_beat(KIND_W'(KIND_SPARE_LO + $urandom_range(0, 2)), rand_word());
        else if (r < 12)
          send_beat(KIND_DUMP, rand_word());
        else if ($urandom_range(0, 99) < push_pct)
          send_beat($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, rand_word());
        else
          send_beat($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK, rand_word());
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    front_slot = 0;
    fill = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_ops();
    test_directed();
    test_fill_stall();
    test_random(300);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d items (%0d dumps), %0d result beats checked",
             items_sent, dumps_sent, beats_checked);
    $display("full refusals %0d, empty reports %0d, mismatches %0d",
             full_refusals, empty_reports, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* double_ended_queue_unit.f */
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue_unit.sv
bench/tb_top.sv
